>>> hdl/position_ordered_slot_table_assert.svh
// Assertion macros shared by the slot table checkers.
// Depends on nothing; the includer supplies signals named clock and reset.
`ifndef POSITION_ORDERED_SLOT_TABLE_ASSERT_SVH
`define POSITION_ORDERED_SLOT_TABLE_ASSERT_SVH

// check cons in the same cycle as ante
`define PST_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// check cons in the cycle after ante
`define PST_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/pst_pkg.sv
// Package for the position ordered slot table: command codes and stream layout.
// Depends on nothing; used by the top level and its checker.
`timescale 1ns / 1ps

package pst_pkg;

   typedef enum logic [1:0] {
      CMD_QUERY  = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_REMOVE = 2'd2
   } cmd_type;

   localparam int CMD_BITS      = 2;
   localparam int POS_BITS      = 6;
   localparam int WORD_BITS     = 32;

   localparam int REQ_CMD_LSB   = 0;
   localparam int REQ_POS_LSB   = REQ_CMD_LSB + CMD_BITS;
   localparam int REQ_DATA_LSB  = REQ_POS_LSB + POS_BITS;
   localparam int REQ_BITS      = REQ_DATA_LSB + WORD_BITS;

   localparam int RSP_VALID_LSB = 0;
   localparam int RSP_SDATA_LSB = RSP_VALID_LSB + 1;
   localparam int RSP_EMPTY_LSB = RSP_SDATA_LSB + WORD_BITS;
   localparam int RSP_HPOS_LSB  = RSP_EMPTY_LSB + 1;
   localparam int RSP_HDATA_LSB = RSP_HPOS_LSB + POS_BITS;
   localparam int RSP_BITS      = RSP_HDATA_LSB + WORD_BITS;

endpackage

>>> hdl/position_ordered_slot_table.sv
// Position ordered slot table: valid bitmap, slot memory and find-first-set head.
// Depends on pst_pkg.
`timescale 1ns / 1ps

// One request per cycle is accepted unless the response side stalls. The
// valid bitmap and its find-first-set are updated as a request leaves the
// request register, the slot memory is read at the addressed slot and at the
// head in that same cycle into the read register, and the read data is merged
// into the response register as it advances. The table is empty the cycle
// after reset; no clearing pass is needed since free slots read as 0.
module position_ordered_slot_table
   import pst_pkg::*;
#(
   parameter int SLOTS     = 64,
   parameter int DATA_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // command[1:0], position[7:2], data_in[39:8]
   input  logic [REQ_BITS-1:0] req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // slot_valid[0], slot_data[32:1], table_empty[33], head_position[39:34],
   // head_data[71:40]
   output logic [RSP_BITS-1:0] rsp_tdata
);

   localparam int IDX_BITS = $clog2(SLOTS);
   localparam int PWIDE    = (IDX_BITS > POS_BITS) ? IDX_BITS : POS_BITS;
   localparam int DWIDE    = (DATA_BITS > WORD_BITS) ? DATA_BITS : WORD_BITS;

   logic                 a_valid_ff, b_valid_ff, rsp_valid_ff;
   logic                 a_en, b_en, out_en, a_go;
   logic [CMD_BITS-1:0]  a_cmd_ff;
   logic [POS_BITS-1:0]  a_pos_ff;
   logic [DATA_BITS-1:0] a_din_ff;
   logic [DWIDE-1:0]     din_wide;

   logic [SLOTS-1:0]     valid_ff, valid_in;
   logic [DATA_BITS-1:0] mem [SLOTS];

   cmd_type              a_cmd;
   logic [PWIDE-1:0]     pos_wide;
   logic [IDX_BITS-1:0]  slot_idx, head_idx;
   logic                 in_range, do_insert, do_remove, slot_valid, empty;

   logic                 b_slot_valid_ff, b_empty_ff, b_slot_hit_ff, b_head_hit_ff;
   logic [IDX_BITS-1:0]  b_head_ff;
   logic [DATA_BITS-1:0] b_din_ff, slot_rd_ff, head_rd_ff;
   logic [DATA_BITS-1:0] slot_data, head_data;
   logic [DWIDE-1:0]     slot_data_wide, head_data_wide;
   logic [PWIDE-1:0]     head_wide;
   logic [RSP_BITS-1:0]  rsp_data_ff, rsp_data_in;

   assign out_en     = !rsp_valid_ff || rsp_tready;
   assign b_en       = !b_valid_ff || out_en;
   assign a_en       = !a_valid_ff || b_en;
   assign a_go       = a_valid_ff && b_en;
   assign req_tready = a_en;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign din_wide = DWIDE'(req_tdata[REQ_DATA_LSB +: WORD_BITS]);

   // decode and bitmap update
   always_comb begin
      a_cmd     = cmd_type'(a_cmd_ff);
      pos_wide  = PWIDE'(a_pos_ff);
      slot_idx  = pos_wide[IDX_BITS-1:0];
      in_range  = 32'(a_pos_ff) < 32'(SLOTS);
      do_insert = in_range && (a_cmd == CMD_INSERT);
      do_remove = in_range && (a_cmd == CMD_REMOVE);
      valid_in  = valid_ff;
      if (a_go && do_insert) begin
         valid_in[slot_idx] = 1'b1;
      end else if (a_go && do_remove) begin
         valid_in[slot_idx] = 1'b0;
      end
      slot_valid = in_range && valid_in[slot_idx];
      empty      = (valid_in == '0);
   end

   // find first set
   always_comb begin
      head_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (valid_in[i]) begin
            head_idx = IDX_BITS'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_go && do_insert) begin
         mem[slot_idx] <= a_din_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_en) begin
         slot_rd_ff <= mem[slot_idx];
         head_rd_ff <= mem[head_idx];
      end
   end

   // merge bypass and read data
   always_comb begin
      slot_data      = !b_slot_valid_ff ? '0 : (b_slot_hit_ff ? b_din_ff : slot_rd_ff);
      head_data      = b_empty_ff ? '0 : (b_head_hit_ff ? b_din_ff : head_rd_ff);
      slot_data_wide = DWIDE'(slot_data);
      head_data_wide = DWIDE'(head_data);
      head_wide      = PWIDE'(b_head_ff);
      rsp_data_in    = {head_data_wide[WORD_BITS-1:0], head_wide[POS_BITS-1:0], b_empty_ff,
                        slot_data_wide[WORD_BITS-1:0], b_slot_valid_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         valid_ff <= valid_in;
         if (a_en) begin
            a_valid_ff <= req_tvalid;
         end
         if (b_en) begin
            b_valid_ff <= a_valid_ff;
         end
         if (out_en) begin
            rsp_valid_ff <= b_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_en) begin
         a_cmd_ff <= req_tdata[REQ_CMD_LSB +: CMD_BITS];
         a_pos_ff <= req_tdata[REQ_POS_LSB +: POS_BITS];
         a_din_ff <= din_wide[DATA_BITS-1:0];
      end
      if (b_en) begin
         b_slot_valid_ff <= slot_valid;
         b_empty_ff      <= empty;
         b_head_ff       <= head_idx;
         b_slot_hit_ff   <= do_insert;
         b_head_hit_ff   <= do_insert && (head_idx == slot_idx);
         b_din_ff        <= a_din_ff;
      end
      if (out_en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

>>> hdl/pst_checker.sv
// Port checker for the position ordered slot table, bound to the top level.
// Depends on pst_pkg and position_ordered_slot_table_assert.svh.
`timescale 1ns / 1ps
`include "position_ordered_slot_table_assert.svh"

module pst_checker
   import pst_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [RSP_BITS-1:0] rsp_tdata
);

   logic                 slot_valid, empty;
   logic [POS_BITS-1:0]  head_pos;
   logic [WORD_BITS-1:0] slot_data, head_data;

   assign slot_valid = rsp_tdata[RSP_VALID_LSB];
   assign slot_data  = rsp_tdata[RSP_SDATA_LSB +: WORD_BITS];
   assign empty      = rsp_tdata[RSP_EMPTY_LSB];
   assign head_pos   = rsp_tdata[RSP_HPOS_LSB +: POS_BITS];
   assign head_data  = rsp_tdata[RSP_HDATA_LSB +: WORD_BITS];

   `PST_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "response changed while stalled")
   `PST_ASSERT_NOW(a_empty_head, rsp_tvalid && empty,
      head_pos == '0 && head_data == '0, "empty table reports a head")
   `PST_ASSERT_NOW(a_slot_not_empty, rsp_tvalid && slot_valid,
      !empty, "occupied slot in an empty table")
   `PST_ASSERT_NOW(a_free_slot_zero, rsp_tvalid && !slot_valid,
      slot_data == '0, "free slot reports data")
   `PST_ASSERT_NOW(a_reset_idle, $past(reset),
      !rsp_tvalid, "response right after reset")

endmodule

bind position_ordered_slot_table pst_checker u_pst_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
